// File: src/acx_pkg.sv
// acx_pkg: shared sizes, register indexes and reset values for the
// adaptive expiry lookup cache. No dependencies.
`default_nettype none
package acx_pkg;
	localparam int MAX_ENTRIES = 128;
	localparam int TAG_BITS    = 32;
	localparam int COUNT_BITS  = 16;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CAP_W       = 7;
	localparam int MARK_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_START = 1'd1;

	localparam logic [CAP_W-1:0]      CAP_RESET  = 7'd100;
	localparam logic [MARK_W-1:0]     MARK_RESET = 16'd64;
	localparam logic [MARK_W-1:0]     MARK_MAX   = 16'hFFFF;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
	// floor(y/3) == (y * RECIP3) >> 17 for any 16-bit y
	localparam logic [15:0]           RECIP3     = 16'd43691;
endpackage
`default_nettype wire

// File: src/acx_ram.sv
// acx_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module acx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/refcount_adaptive_cache_expiry.sv
// a hit stops the tag scan, which walks slots in order, at the matching slot; a miss
// walks every slot, and an expiry pass runs when the entry count exceeds capacity:
// two walks of the age list through the age and count memories, then a mark update.
// one word is in flight at a time; the next word is taken as soon as the
// result register is loaded. reset clears the entry count, valid bits and
// age head, and loads capacity 100 and mark 64; memories are not cleared.
`default_nettype none
module refcount_adaptive_cache_expiry (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [acx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [acx_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [acx_pkg::TAG_BITS-1:0]      lookup_key,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic      [acx_pkg::ADDR_W-1:0]        slot_index,
	output logic      [acx_pkg::ADDR_W-1:0]        expired_count,
	output logic      [acx_pkg::CNT_W-1:0]         entries_held
);
	import acx_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_MISS   = 4'd2;
	localparam logic [3:0] S_DROP   = 4'd3;
	localparam logic [3:0] S_INSERT = 4'd4;
	localparam logic [3:0] S_EXPI   = 4'd5;
	localparam logic [3:0] S_THR    = 4'd6;
	localparam logic [3:0] S_SWEEP  = 4'd7;
	localparam logic [3:0] S_MARK   = 4'd8;
	localparam logic [3:0] S_MDIV   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]             state_q;
	logic [TAG_BITS-1:0]    key_q;
	logic [ADDR_W-1:0]      head_q;
	logic [CNT_W-1:0]       ecnt_q;
	logic [MARK_W-1:0]      mark_q;
	logic [CAP_W-1:0]       cap_q;
	logic [MAX_ENTRIES-1:0] valid_q;

	logic [CNT_W-1:0]       sidx_q;
	logic                   iss_s1;
	logic                   sv_s1;
	logic [ADDR_W-1:0]      sidx_s1;
	logic [ADDR_W-1:0]      free_q;
	logic                   free_found_q;

	logic [CNT_W-1:0]       p_q, lim_q, size_q, keep_q, rem_q;
	logic [COUNT_BITS-1:0]  thr_q;
	logic                   thr_set_q;
	logic                   v1_s1, v2_s2;
	logic [ADDR_W-1:0]      slot_s2;
	logic [ADDR_W-1:0]      new_slot_q;
	logic [31:0]            prod_q;

	logic                   res_hit_q;
	logic [ADDR_W-1:0]      res_slot_q;
	logic [CNT_W-1:0]       res_rem_q;

	// memory ports
	logic                   tag_we, tag_re, cnt_we, cnt_re, age_we, age_re;
	logic [ADDR_W-1:0]      tag_waddr, tag_raddr, cnt_waddr, cnt_raddr, age_waddr, age_raddr;
	logic [TAG_BITS-1:0]    tag_rd;
	logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rd;
	logic [ADDR_W-1:0]      age_wdata, age_rd;

	logic                   scan_issue, hit_now, walk_issue;
	logic [CNT_W-1:0]       ecnt_inc;
	logic [MARK_W-1:0]      half_m, size_m, mark_c, win_m;
	logic [16:0]            mark_up;
	logic [15:0]            rem_x5;
	logic                   out_load;

	assign scan_issue = (state_q == S_SCAN) && !sidx_q[ADDR_W] && !hit_now;
	assign hit_now    = (state_q == S_SCAN) && iss_s1 && sv_s1 && (tag_rd == key_q);
	assign walk_issue = ((state_q == S_THR) || (state_q == S_SWEEP)) && (p_q < lim_q);
	assign ecnt_inc   = ecnt_q + 1'b1;

	assign size_m = MARK_W'(ecnt_q);
	assign half_m = size_m >> 1;
	assign mark_c = (mark_q > half_m) ? half_m : mark_q;
	always_comb begin
		win_m = (mark_c == '0) ? MARK_W'(1) : mark_c;
		if (win_m > size_m) begin
			win_m = size_m;
		end
	end
	assign mark_up = {1'b0, mark_q} + {2'b0, mark_q[MARK_W-1:1]};
	assign rem_x5  = (16'(rem_q) + 16'd1) * 16'd5;

	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid || !out_stall);

	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = new_slot_q;
		tag_re    = scan_issue;
		tag_raddr = sidx_q[ADDR_W-1:0];
		cnt_we    = 1'b0;
		cnt_waddr = new_slot_q;
		cnt_wdata = COUNT_BITS'(1);
		cnt_re    = scan_issue;
		cnt_raddr = sidx_q[ADDR_W-1:0];
		age_we    = 1'b0;
		age_waddr = head_q - 1'b1;
		age_wdata = new_slot_q;
		age_re    = 1'b0;
		age_raddr = head_q - 1'b1;
		case (state_q)
			S_SCAN: begin
				if (hit_now) begin
					cnt_we    = 1'b1;
					cnt_waddr = sidx_s1;
					cnt_wdata = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
				end
			end
			S_MISS: begin
				age_re = ecnt_q[ADDR_W];
			end
			S_INSERT: begin
				tag_we = 1'b1;
				cnt_we = 1'b1;
				age_we = 1'b1;
			end
			S_THR, S_SWEEP: begin
				age_re    = walk_issue;
				age_raddr = head_q + p_q[ADDR_W-1:0];
				cnt_re    = v1_s1;
				cnt_raddr = age_rd;
				if ((state_q == S_SWEEP) && v2_s2 && (cnt_rd > thr_q)) begin
					age_we    = 1'b1;
					age_waddr = head_q + keep_q[ADDR_W-1:0];
					age_wdata = slot_s2;
				end
			end
			default: begin
			end
		endcase
	end

	acx_ram #(.WIDTH(TAG_BITS), .DEPTH(MAX_ENTRIES)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(key_q),
		.re(tag_re), .raddr(tag_raddr), .rdata(tag_rd)
	);
	acx_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_ENTRIES)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rd)
	);
	acx_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_age_ram (
		.clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_wdata),
		.re(age_re), .raddr(age_raddr), .rdata(age_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			ecnt_q       <= '0;
			mark_q       <= MARK_RESET;
			cap_q        <= CAP_RESET;
			valid_q      <= '0;
			sidx_q       <= '0;
			iss_s1       <= 1'b0;
			free_found_q <= 1'b0;
			v1_s1        <= 1'b0;
			v2_s2        <= 1'b0;
			thr_set_q    <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CAPACITY:   cap_q  <= cfg_data[CAP_W-1:0];
					REG_MARK_START: mark_q <= cfg_data[MARK_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sidx_q       <= '0;
						iss_s1       <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					iss_s1 <= scan_issue;
					if (scan_issue) begin
						sidx_q <= sidx_q + 1'b1;
						if (!valid_q[sidx_q[ADDR_W-1:0]] && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
					if (hit_now) begin
						state_q <= S_DONE;
					end else if (!scan_issue && !iss_s1) begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					state_q <= ecnt_q[ADDR_W] ? S_DROP : S_INSERT;
				end
				S_DROP: begin
					// full store: reuse the oldest entry's slot
					ecnt_q  <= ecnt_q - 1'b1;
					state_q <= S_INSERT;
				end
				S_INSERT: begin
					head_q              <= head_q - 1'b1;
					valid_q[new_slot_q] <= 1'b1;
					ecnt_q              <= ecnt_inc;
					state_q <= (16'(ecnt_inc) > 16'(cap_q)) ? S_EXPI : S_DONE;
				end
				S_EXPI: begin
					mark_q    <= mark_c;
					size_q    <= ecnt_q;
					lim_q     <= CNT_W'(win_m);
					keep_q    <= CNT_W'(win_m);
					p_q       <= '0;
					rem_q     <= '0;
					thr_set_q <= 1'b0;
					v1_s1     <= 1'b0;
					v2_s2     <= 1'b0;
					state_q   <= S_THR;
				end
				S_THR: begin
					v1_s1 <= walk_issue;
					v2_s2 <= v1_s1;
					if (walk_issue) begin
						p_q <= p_q + 1'b1;
					end
					if (v2_s2 && (!thr_set_q || cnt_rd < thr_q)) begin
						thr_set_q <= 1'b1;
					end
					if (!walk_issue && !v1_s1 && !v2_s2) begin
						lim_q   <= size_q;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					v1_s1 <= walk_issue;
					v2_s2 <= v1_s1;
					if (walk_issue) begin
						p_q <= p_q + 1'b1;
					end
					if (v2_s2) begin
						if (cnt_rd <= thr_q) begin
							valid_q[slot_s2] <= 1'b0;
							rem_q            <= rem_q + 1'b1;
						end else begin
							keep_q <= keep_q + 1'b1;
						end
					end
					if (!walk_issue && !v1_s1 && !v2_s2) begin
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					ecnt_q  <= keep_q;
					state_q <= S_DONE;
					if (rem_q > (size_q >> 1)) begin
						state_q <= S_MDIV;
					end else if (rem_x5 <= 16'(size_q)) begin
						mark_q <= mark_up[16] ? MARK_MAX : mark_up[MARK_W-1:0];
					end
				end
				S_MDIV: begin
					mark_q  <= MARK_W'(prod_q[31:17]);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		sidx_s1 <= sidx_q[ADDR_W-1:0];
		sv_s1   <= valid_q[sidx_q[ADDR_W-1:0]];
		slot_s2 <= age_rd;
		prod_q  <= {mark_q[14:0], 1'b0} * RECIP3;
		if (state_q == S_IDLE && in_valid) begin
			key_q <= lookup_key;
		end
		if (scan_issue && !valid_q[sidx_q[ADDR_W-1:0]] && !free_found_q) begin
			free_q <= sidx_q[ADDR_W-1:0];
		end
		if (state_q == S_MISS) begin
			new_slot_q <= free_q;
		end
		if (state_q == S_DROP) begin
			new_slot_q <= age_rd;
		end
		if (state_q == S_THR && v2_s2 && (!thr_set_q || cnt_rd < thr_q)) begin
			thr_q <= cnt_rd;
		end
		if (hit_now) begin
			res_hit_q  <= 1'b1;
			res_slot_q <= sidx_s1;
			res_rem_q  <= '0;
		end
		if (state_q == S_INSERT) begin
			res_hit_q  <= 1'b0;
			res_slot_q <= new_slot_q;
			res_rem_q  <= '0;
		end
		if (state_q == S_MARK) begin
			res_rem_q <= rem_q;
		end
		if (out_load) begin
			hit           <= res_hit_q;
			slot_index    <= res_slot_q;
			expired_count <= res_rem_q[ADDR_W-1:0];
			entries_held  <= ecnt_q;
		end
	end
endmodule
`default_nettype wire

// File: src/acx_checker.sv
// acx_checker: port-level assertions for the expiry cache, bound to the top level.
// Depends on acx_pkg and refcount_adaptive_cache_expiry.
`default_nettype none
module acx_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic                          hit,
	input wire logic [acx_pkg::ADDR_W-1:0]    slot_index,
	input wire logic [acx_pkg::ADDR_W-1:0]    expired_count,
	input wire logic [acx_pkg::CNT_W-1:0]     entries_held
);
	import acx_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_index))
		else $error("stalled result word dropped or changed");

	a_hit_no_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> expired_count == '0)
		else $error("hit word reports expired entries");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_held != '0 && entries_held <= CNT_W'(MAX_ENTRIES))
		else $error("entries held out of range");

	a_expired_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> CNT_W'(expired_count) < CNT_W'(MAX_ENTRIES))
		else $error("expired count exceeds store");
endmodule

bind refcount_adaptive_cache_expiry acx_checker u_acx_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.hit(hit), .slot_index(slot_index), .expired_count(expired_count),
	.entries_held(entries_held)
);
`default_nettype wire
